[rtl/crc8bfr_pkg.sv]
package crc8bfr_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned LenW       = 7;

  localparam logic [7:0] StartByte = 8'hAA;
  localparam logic [7:0] EndByte   = 8'h55;
  localparam logic [7:0] CrcPoly   = 8'h31;
  localparam logic [7:0] CrcTop    = 8'h80;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_ID,
    ST_CMD,
    ST_LENH,
    ST_LENL,
    ST_DATA,
    ST_CRC,
    ST_END,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load_id;
    logic load_cmd;
    logic load_lenh;
    logic load_lenl;
    logic store_data;
    logic check_crc;
    logic rd_clear;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic len_too_long;
    logic len_zero;
    logic data_done;
    logic end_good;
    logic out_free;
    logic emit_last;
  } status_t;

  // MSB-first CRC-8, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/crc8_byte_frame_receiver.sv]
// Byte-stream frame receiver. Takes one received byte per beat on rx_*, hunts
// for the start byte 0xAA, then gathers frame id, command, a big-endian 16-bit
// length, the payload, a CRC-8 byte and the end byte 0x55. The CRC is MSB-first,
// polynomial 0x31, init 0x00, no final xor, over id, command, both length bytes
// and payload. Frames with a length over 64, with a bad CRC or a wrong end byte
// are dropped without notice and hunting resumes with the next byte. A good
// frame yields one result beat per payload byte (in order, last on the final
// one), or a single header-only beat with has_payload low for an empty frame.
// Rate: one input byte per cycle while parsing. Once the end byte of a good
// frame is taken the input stalls while the payload store is read out, one
// result per cycle when the sink is ready; the single read port of the payload
// store sets the readout pace. The result register lets parsing of the next
// frame start while the final beat of the previous one still waits.
module crc8_byte_frame_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   link_id_o,
  output logic [7:0]                   command_o,
  output logic [crc8bfr_pkg::LenW-1:0] payload_length_o,
  output logic                         has_payload_o,
  output logic [7:0]                   payload_byte_o,
  output logic [crc8bfr_pkg::IdxW-1:0] byte_index_o,
  output logic                         last_o
);
  import crc8bfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the frame fields and the readout
  crc8bfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold header, CRC, payload store and the result register
  crc8bfr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .link_id_o        (link_id_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .has_payload_o    (has_payload_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .last_o           (last_o)
  );

endmodule

[rtl/crc8bfr_ctrl.sv]
module crc8bfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  crc8bfr_pkg::status_t status_i,
  output crc8bfr_pkg::cmd_t    cmd_o
);
  import crc8bfr_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  assign rx_ready_o = (state_q != ST_OUT);
  assign in_fire    = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_HUNT: begin
        if (in_fire && status_i.is_start) state_d = ST_ID;
      end
      ST_ID: begin
        if (in_fire) state_d = ST_CMD;
      end
      ST_CMD: begin
        if (in_fire) state_d = ST_LENH;
      end
      ST_LENH: begin
        if (in_fire) state_d = ST_LENL;
      end
      ST_LENL: begin
        if (in_fire) begin
          if (status_i.len_too_long) begin
            state_d = ST_HUNT;
          end else if (status_i.len_zero) begin
            state_d = ST_CRC;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_fire && status_i.data_done) state_d = ST_CRC;
      end
      ST_CRC: begin
        if (in_fire) state_d = ST_END;
      end
      ST_END: begin
        if (in_fire) state_d = status_i.end_good ? ST_OUT : ST_HUNT;
      end
      ST_OUT: begin
        if (status_i.out_free && status_i.emit_last) state_d = ST_HUNT;
      end
      default: state_d = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_HUNT: cmd_o.clear      = in_fire && status_i.is_start;
      ST_ID:   cmd_o.load_id    = in_fire;
      ST_CMD:  cmd_o.load_cmd   = in_fire;
      ST_LENH: cmd_o.load_lenh  = in_fire;
      ST_LENL: cmd_o.load_lenl  = in_fire;
      ST_DATA: cmd_o.store_data = in_fire;
      ST_CRC:  cmd_o.check_crc  = in_fire;
      ST_END:  cmd_o.rd_clear   = in_fire;
      ST_OUT:  cmd_o.emit       = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/crc8bfr_dp.sv]
module crc8bfr_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [7:0]                      rx_byte_i,
  input  crc8bfr_pkg::cmd_t               cmd_i,
  output crc8bfr_pkg::status_t            status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      link_id_o,
  output logic [7:0]                      command_o,
  output logic [crc8bfr_pkg::LenW-1:0]    payload_length_o,
  output logic                            has_payload_o,
  output logic [7:0]                      payload_byte_o,
  output logic [crc8bfr_pkg::IdxW-1:0]    byte_index_o,
  output logic                            last_o
);
  import crc8bfr_pkg::*;

  logic [7:0]      id_q, cmd_q, lenh_q, crc_q;
  logic [LenW-1:0] len_q, count_q, count_inc, idx_inc;
  logic            crc_bad_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0]     len16;
  logic [7:0]      mem [StoreDepth];

  logic            out_valid_q, out_has_q, out_last_q;
  logic [7:0]      out_id_q, out_cmd_q, rd_q;
  logic [LenW-1:0] out_len_q;
  logic [IdxW-1:0] out_idx_q;

  assign len16     = {lenh_q, rx_byte_i};
  assign count_inc = LenW'(count_q + 1'b1);
  assign idx_inc   = LenW'({1'b0, idx_q} + 1'b1);

  always_comb begin
    status_o.is_start     = (rx_byte_i == StartByte);
    status_o.len_too_long = (len16 > 16'(MaxPayload));
    status_o.len_zero     = (len16 == 16'h0000);
    status_o.data_done    = (count_inc >= len_q);
    status_o.end_good     = (rx_byte_i == EndByte) && !crc_bad_q;
    status_o.out_free     = !out_valid_q || out_ready_i;
    status_o.emit_last    = (len_q == '0) || (idx_inc == len_q);
  end

  // Frame header, length, count and CRC
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q      <= '0;
      cmd_q     <= '0;
      lenh_q    <= '0;
      len_q     <= '0;
      count_q   <= '0;
      crc_q     <= '0;
      crc_bad_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        crc_q     <= '0;
        count_q   <= '0;
        crc_bad_q <= 1'b0;
      end
      if (cmd_i.load_id) id_q <= rx_byte_i;
      if (cmd_i.load_cmd) cmd_q <= rx_byte_i;
      if (cmd_i.load_lenh) lenh_q <= rx_byte_i;
      if (cmd_i.load_lenl) begin
        len_q   <= len16[LenW-1:0];
        count_q <= '0;
      end
      if (cmd_i.load_id || cmd_i.load_cmd || cmd_i.load_lenh || cmd_i.load_lenl ||
          cmd_i.store_data) begin
        crc_q <= crc8_update(crc_q, rx_byte_i);
      end
      if (cmd_i.store_data) count_q <= count_inc;
      if (cmd_i.check_crc) crc_bad_q <= (rx_byte_i != crc_q);
      if (cmd_i.rd_clear) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_inc[IdxW-1:0];
      end
    end
  end

  // Payload store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_data) mem[count_q[IdxW-1:0]] <= rx_byte_i;
    if (cmd_i.emit) rd_q <= mem[idx_q];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_id_q   <= id_q;
      out_cmd_q  <= cmd_q;
      out_len_q  <= len_q;
      out_has_q  <= (len_q != '0);
      out_idx_q  <= idx_q;
      out_last_q <= status_o.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign link_id_o        = out_id_q;
  assign command_o        = out_cmd_q;
  assign payload_length_o = out_len_q;
  assign has_payload_o    = out_has_q;
  assign payload_byte_o   = out_has_q ? rd_q : 8'h00;
  assign byte_index_o     = out_idx_q;
  assign last_o           = out_last_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_data |-> (count_q < len_q))
    else $error("payload write beyond declared length");

  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (len_q != '0)) |-> ({1'b0, idx_q} < len_q))
    else $error("payload read beyond declared length");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule
